### hdl/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

  localparam int unsigned RomImageBits = 21;
  localparam int unsigned AddrW        = 16;
  localparam int unsigned DataW        = 8;
  localparam int unsigned PhysW        = 21;
  localparam int unsigned RomBankW     = 8;
  localparam int unsigned RamBankW     = 2;
  localparam int unsigned RomOffW      = 14;
  localparam int unsigned RamOffW      = 13;
  localparam int unsigned RomFullW     = RomBankW + RomOffW;

  localparam logic [RomFullW-1:0] RomMask =
    RomFullW'((64'd1 << RomImageBits) - 64'd1);

  localparam logic [3:0]       EnableKey   = 4'hA;
  localparam logic [AddrW-1:0] Mbc2RamTop  = 16'hA200;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC2 = 2'd2,
    KIND_RSVD = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TGT_PLAIN = 2'd0,
    TGT_ROM   = 2'd1,
    TGT_RAM   = 2'd2,
    TGT_CTRL  = 2'd3
  } target_e;

  typedef struct packed {
    logic             is_write;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } access_t;

  typedef struct packed {
    logic [RomBankW-1:0] rom_bank;
    logic [RamBankW-1:0] ram_bank;
    logic                ram_enabled;
    logic                mode_rom16;
  } bank_state_t;

  typedef struct packed {
    target_e          target;
    logic [PhysW-1:0] phys;
    logic             allowed;
  } result_t;

endpackage

`default_nettype wire

### hdl/cbm_bank_regs.sv
`default_nettype none

module cbm_bank_regs
  import cbm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_kind_i,
  input  wire logic        upd_i,
  input  wire access_t     acc_i,
  output bank_state_t      state_o,
  output kind_e            kind_o
);

  bank_state_t state_q, state_d;
  kind_e       kind_q;

  logic [4:0] low5;
  logic [3:0] low4;

  always_comb begin
    state_d = state_q;
    low5    = (acc_i.data[4:0] == 5'd0) ? 5'd1 : acc_i.data[4:0];
    low4    = (acc_i.data[3:0] == 4'd0) ? 4'd1 : acc_i.data[3:0];
    if (acc_i.is_write && !acc_i.addr[15]) begin
      case (acc_i.addr[14:13])
        2'b00: begin
          if (kind_q == KIND_MBC1 || (kind_q == KIND_MBC2 && !acc_i.addr[8])) begin
            if (acc_i.data[3:0] == EnableKey) begin
              state_d.ram_enabled = 1'b1;
            end else if (acc_i.data == '0) begin
              state_d.ram_enabled = 1'b0;
            end
          end
        end
        2'b01: begin
          if (kind_q == KIND_MBC1) begin
            state_d.rom_bank = {state_q.rom_bank[7:5], low5};
          end else if (kind_q == KIND_MBC2) begin
            state_d.rom_bank = {4'd0, low4};
          end
        end
        2'b10: begin
          if (kind_q == KIND_MBC1) begin
            if (state_q.mode_rom16) begin
              state_d.ram_bank = '0;
              state_d.rom_bank = {1'b0, acc_i.data[1:0],
                                  (state_q.rom_bank[4:0] == 5'd0) ? 5'd1
                                                                  : state_q.rom_bank[4:0]};
            end else begin
              state_d.ram_bank = acc_i.data[1:0];
            end
          end
        end
        default: begin
          if (kind_q == KIND_MBC1) begin
            if (acc_i.data[0]) begin
              state_d.ram_bank   = '0;
              state_d.mode_rom16 = 1'b0;
            end else begin
              state_d.mode_rom16 = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.rom_bank    <= RomBankW'(1);
      state_q.ram_bank    <= '0;
      state_q.ram_enabled <= 1'b0;
      state_q.mode_rom16  <= 1'b1;
      kind_q              <= KIND_NONE;
    end else begin
      if (upd_i) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        kind_q <= kind_e'(cfg_kind_i);
      end
    end
  end

  assign state_o = state_q;
  assign kind_o  = kind_q;

endmodule

`default_nettype wire

### hdl/cbm_decode.sv
`default_nettype none

module cbm_decode
  import cbm_pkg::*;
(
  input  wire access_t     acc_i,
  input  wire bank_state_t state_i,
  input  wire kind_e       kind_i,
  output result_t          res_o
);

  logic [RomFullW-1:0] rom_full;

  always_comb begin
    rom_full    = {state_i.rom_bank, acc_i.addr[RomOffW-1:0]} & RomMask;
    res_o.target  = TGT_PLAIN;
    res_o.phys    = PhysW'(acc_i.addr);
    res_o.allowed = 1'b0;
    if (acc_i.is_write && !acc_i.addr[15]) begin
      res_o.target = TGT_CTRL;
    end else if (acc_i.addr[15:14] == 2'b01) begin
      res_o.target = TGT_ROM;
      res_o.phys   = rom_full[PhysW-1:0];
    end else if (acc_i.addr[15:13] == 3'b101) begin
      res_o.target = TGT_RAM;
      res_o.phys   = PhysW'({state_i.ram_bank, acc_i.addr[RamOffW-1:0]});
      if (acc_i.is_write && state_i.ram_enabled) begin
        res_o.allowed = (kind_i == KIND_MBC1) ||
                        (kind_i == KIND_MBC2 && acc_i.addr < Mbc2RamTop);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/cartridge_bank_mapper_unit.sv
// Cartridge bank controller, MBC1 / MBC2 style.
// Input channel (in_valid_i / in_stall_o): one CPU bus access per
// transaction: mode_i (0 read, 1 write), bus_address_i, write_data_i.
// Output channel (out_valid_o / out_stall_i): one result per access:
// target_o, physical_address_o, ram_write_allowed_o.
// Config channel (cfg_valid_i / cfg_ready_o): cfg_data_i sets the
// controller kind (0 none, 1 MBC1, 2 MBC2); always ready; write only
// while no access is in flight.
// Path: each access passes the input register, then the result register.
// Throughput: one access per cycle while the output is not stalled, with the
// bank registers updated between the two registers.
// Reset: rom bank 1, ram bank 0, RAM disabled, ROM-16/RAM-8 mode,
// kind none; both pipeline registers empty.
// A stalled result holds; the input register still accepts one more
// access, and in_stall_o rises only when both registers are full.
`default_nettype none

module cartridge_bank_mapper_unit
  import cbm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire logic [1:0]       cfg_data_i,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire logic             mode_i,
  input  wire logic [AddrW-1:0] bus_address_i,
  input  wire logic [DataW-1:0] write_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      logic [1:0]       target_o,
  output      logic [PhysW-1:0] physical_address_o,
  output      logic             ram_write_allowed_o
);

  logic        in_valid_q;
  access_t     acc_q;
  logic        out_valid_q;
  result_t     res_q;
  result_t     res_d;
  bank_state_t state;
  kind_e       kind;
  logic        advance;
  logic        accept;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  cbm_bank_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_kind_i (cfg_data_i),
    .upd_i      (advance),
    .acc_i      (acc_q),
    .state_o    (state),
    .kind_o     (kind)
  );

  cbm_decode u_decode (
    .acc_i   (acc_q),
    .state_i (state),
    .kind_i  (kind),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= '{is_write: mode_i, addr: bus_address_i, data: write_data_i};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign target_o            = res_q.target;
  assign physical_address_o  = res_q.phys;
  assign ram_write_allowed_o = res_q.allowed;

endmodule

`default_nettype wire
